// ===== hw/rtl/aes_sbox_forward_macros.svh =====
// Assertion macros shared by the S-box RTL.
// Each macro takes a label, the clock, the active-low reset, and two expressions.
`ifndef AES_SBOX_FORWARD_MACROS_SVH
`define AES_SBOX_FORWARD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("S-box pipeline check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("S-box pipeline check failed");

`endif

// ===== hw/rtl/asf_pkg.sv =====
package asf_pkg;

	// Field width and the low byte of the reduction polynomial x^8+x^4+x^3+x+1.
	localparam int unsigned FIELD_W = 8;
	localparam logic [7:0] POLY_LOW = 8'h1B;
	localparam logic [8:0] POLY_FULL = 9'h11B;

	// Constant added after the affine matrix.
	localparam logic [7:0] AFFINE_C = 8'h63;

	// Squaring in GF(2^8) is linear: spread the bits, then reduce the high terms.
	function automatic logic [7:0] gf_sq(input logic [7:0] a);
		logic [14:0] w;
		w = '0;
		for (int i = 0; i < 8; i++) begin
			w[2*i] = a[i];
		end
		for (int k = 14; k >= 8; k--) begin
			if (w[k]) begin
				w[k -: 9] = w[k -: 9] ^ POLY_FULL;
			end
		end
		return w[7:0];
	endfunction

	// Four squarings in a row give the sixteenth power.
	function automatic logic [7:0] gf_pow16(input logic [7:0] a);
		return gf_sq(gf_sq(gf_sq(gf_sq(a))));
	endfunction

	// Circulant affine map with first row 1,0,0,0,1,1,1,1, then the constant.
	function automatic logic [7:0] gf_affine(input logic [7:0] x);
		logic [7:0] r1;
		logic [7:0] r2;
		logic [7:0] r3;
		logic [7:0] r4;
		r1 = {x[6:0], x[7]};
		r2 = {x[5:0], x[7:6]};
		r3 = {x[4:0], x[7:5]};
		r4 = {x[3:0], x[7:4]};
		return x ^ r1 ^ r2 ^ r3 ^ r4 ^ AFFINE_C;
	endfunction

endpackage

// ===== hw/rtl/asf_gf_mul.sv =====
// Combinational multiplier in GF(2^8), reduced by the AES polynomial.
module asf_gf_mul (
	input  logic [7:0] a,
	input  logic [7:0] b,
	output logic [7:0] p
);

	logic [7:0] acc;
	logic [7:0] sh;

	// Shift-and-add over the bits of b, reducing the shifted operand each step.
	always_comb begin
		acc = '0;
		sh = a;
		for (int k = 0; k < asf_pkg::FIELD_W; k++) begin
			if (b[k]) begin
				acc = acc ^ sh;
			end
			if (sh[7]) begin
				sh = {sh[6:0], 1'b0} ^ asf_pkg::POLY_LOW;
			end else begin
				sh = {sh[6:0], 1'b0};
			end
		end
	end

	assign p = acc;

endmodule

// ===== hw/rtl/aes_sbox_forward.sv =====
// AES forward S-box, one byte per transaction.
// Input channel: in_valid, in_byte, and in_stall driven by this block.
// Output channel: out_valid, out_byte, and out_stall driven by the receiver.
// A transaction takes place at a rising edge where valid is high and stall is low.
// The inverse is computed as x^254 over four register stages, each holding one
// field multiplier; the affine map follows the last multiplier in stage four.
// A byte moves through the registers of stages one to four in turn; out_valid is
// the stage-four valid bit, and a stall can hold a byte in any stage.
// Throughput is one byte per cycle while the receiver takes results.
// When out_stall is high, the result holds on out_byte and the stages behind
// it fill up; in_stall rises only once every stage holds a byte, and no byte
// is lost or repeated.
// Reset clears all valid bits; the pipeline then accepts input at once.
`include "aes_sbox_forward_macros.svh"

module aes_sbox_forward (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	logic [7:0] x2_s1, x3_s1;
	logic [7:0] x2_s2, x12_s2, x15_s2;
	logic [7:0] x2_s3, x252_s3;
	logic [7:0] out_s4;

	logic [7:0] x2_c, x3_c, x12_c, x15_c, x240_c, x252_c, x254_c;

	// A stage may load when it is empty or when its content moves on.
	assign ready_s4 = !valid_s4 || !out_stall;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	// Stage one: x^2 and x^3.
	assign x2_c = asf_pkg::gf_sq(in_byte);
	asf_gf_mul u_mul1 (.a(x2_c), .b(in_byte), .p(x3_c));

	// Stage two: x^12 from x^3, then x^15.
	assign x12_c = asf_pkg::gf_sq(asf_pkg::gf_sq(x3_s1));
	asf_gf_mul u_mul2 (.a(x12_c), .b(x3_s1), .p(x15_c));

	// Stage three: x^240 from x^15, then x^252.
	assign x240_c = asf_pkg::gf_pow16(x15_s2);
	asf_gf_mul u_mul3 (.a(x240_c), .b(x12_s2), .p(x252_c));

	// Stage four: x^254 is the inverse, with zero mapping to zero.
	asf_gf_mul u_mul4 (.a(x252_s3), .b(x2_s3), .p(x254_c));

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// Payload registers load only when a byte moves into the stage.
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			x2_s1 <= x2_c;
			x3_s1 <= x3_c;
		end
		if (ready_s2 && valid_s1) begin
			x2_s2  <= x2_s1;
			x12_s2 <= x12_c;
			x15_s2 <= x15_c;
		end
		if (ready_s3 && valid_s2) begin
			x2_s3   <= x2_s2;
			x252_s3 <= x252_c;
		end
		if (ready_s4 && valid_s3) begin
			out_s4 <= asf_pkg::gf_affine(x254_c);
		end
	end

	assign out_valid = valid_s4;
	assign out_byte  = out_s4;

	// An accepted input transaction always lands in stage one.
	`ASF_ASSERT_NEXT(a_in_lands, clk, arst_n, in_valid && !in_stall, valid_s1)
	// An empty output stage always takes a waiting stage-three byte.
	`ASF_ASSERT_NEXT(a_s3_moves, clk, arst_n, valid_s3 && !valid_s4, out_valid)
	// A taken result with nothing behind it leaves the output empty.
	`ASF_ASSERT_NEXT(a_no_repeat, clk, arst_n, out_valid && !out_stall && !valid_s3,
		!out_valid)
	// Input is stalled only when every stage is occupied.
	`ASF_ASSERT_SAME(a_stall_full, clk, arst_n, in_stall,
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && out_stall)

endmodule
